@@ rtl/core/lspid_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspid_pkg
// Shared types, widths and constants of the line sensor PID steering block.
// ----------------------------------------------------------------------------
package lspid_pkg;

	localparam int NUM_SENSORS    = 15;
	localparam int IDX_W          = 4;
	localparam int THRESH_W       = 12;
	localparam int GAIN_W         = 8;
	localparam int SPEED_W        = 8;
	localparam int ERR_W          = 6;
	localparam int WEIGHT_W       = 4;
	localparam int TURN_W         = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 12;
	localparam int OVERRIDE_LIMIT = 10;
	localparam int ERROR_LIMIT    = 21;

	localparam logic [IDX_W-1:0] FRONT_INDEX = 4'd15;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD  = 3'd0,
		REG_GAIN_P     = 3'd1,
		REG_GAIN_I     = 3'd2,
		REG_GAIN_D     = 3'd3,
		REG_BASE_SPEED = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic        [THRESH_W-1:0] threshold;
		logic signed [GAIN_W-1:0]   gain_p;
		logic signed [GAIN_W-1:0]   gain_i;
		logic signed [GAIN_W-1:0]   gain_d;
		logic signed [SPEED_W-1:0]  base_speed;
	} cfg_t;

	typedef struct packed {
		logic                    valid;
		logic signed [ERR_W-1:0] err;
		logic signed [ERR_W:0]   diff;
	} err_stage_t;

	// Position weight of each line sensor, left to right.
	function automatic logic signed [WEIGHT_W-1:0] sensor_weight(input logic [IDX_W-1:0] idx);
		logic signed [WEIGHT_W-1:0] w;
		case (idx)
			4'd0, 4'd1:        w = -4'sd4;
			4'd2, 4'd3, 4'd4:  w = -4'sd3;
			4'd5, 4'd6:        w = -4'sd2;
			4'd8, 4'd9:        w = 4'sd2;
			4'd10, 4'd11, 4'd12: w = 4'sd3;
			4'd13, 4'd14:      w = 4'sd4;
			default:           w = 4'sd0;
		endcase
		return w;
	endfunction

endpackage

@@ rtl/core/lspid_sample_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspid_sample_if
// Sensor sample channel: one reflectance sample per transfer.
// ----------------------------------------------------------------------------
interface lspid_sample_if #(
	parameter int SAMPLE_BITS = 12
);
	import lspid_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [IDX_W-1:0]       sensor_index;
	logic [SAMPLE_BITS-1:0] sensor_value;

	modport source (output valid, output sensor_index, output sensor_value, input ready);
	modport sink   (input valid, input sensor_index, input sensor_value, output ready);
endinterface

@@ rtl/core/lspid_steer_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspid_steer_if
// Steering result channel: turn rate, speed and line error per transfer.
// ----------------------------------------------------------------------------
interface lspid_steer_if;
	import lspid_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [TURN_W-1:0]  turn_rate;
	logic signed [SPEED_W-1:0] drive_speed;
	logic signed [ERR_W-1:0]   line_error;

	modport source (output valid, output turn_rate, output drive_speed, output line_error,
		input ready);
	modport sink   (input valid, input turn_rate, input drive_speed, input line_error,
		output ready);
endinterface

@@ rtl/core/lspid_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspid_cfg_if
// Configuration write channel: register index and write data per transfer.
// ----------------------------------------------------------------------------
interface lspid_cfg_if;
	import lspid_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/lspid_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspid_cfg_regs
// Configuration register file: threshold, PID gains and base speed.
// ----------------------------------------------------------------------------
module lspid_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	lspid_cfg_if.sink         cfg,
	output lspid_pkg::cfg_t   cfg_o
);
	import lspid_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign cfg_o     = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.threshold  <= THRESH_W'(800);
			regs_q.gain_p     <= GAIN_W'(12);
			regs_q.gain_i     <= '0;
			regs_q.gain_d     <= '0;
			regs_q.base_speed <= SPEED_W'(30);
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_THRESHOLD:  regs_q.threshold  <= cfg.data;
				REG_GAIN_P:     regs_q.gain_p     <= cfg.data[GAIN_W-1:0];
				REG_GAIN_I:     regs_q.gain_i     <= cfg.data[GAIN_W-1:0];
				REG_GAIN_D:     regs_q.gain_d     <= cfg.data[GAIN_W-1:0];
				REG_BASE_SPEED: regs_q.base_speed <= cfg.data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/core/lspid_error_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspid_error_stage
// Input register, weighted frame error, front override and saturating integral.
// ----------------------------------------------------------------------------
module lspid_error_stage #(
	parameter int SAMPLE_BITS   = 12,
	parameter int INTEGRAL_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	lspid_sample_if.sink                    sample,
	input  lspid_pkg::cfg_t                 cfg,
	output lspid_pkg::err_stage_t           stage_o,
	output logic signed [INTEGRAL_BITS-1:0] integ_o,
	input  logic                            stage_ready
);
	import lspid_pkg::*;

	localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
	localparam logic signed [ERR_W:0]   ERR_HI = (ERR_W+1)'(ERROR_LIMIT);
	localparam logic signed [ERR_W:0]   ERR_LO = -ERR_HI;
	localparam logic signed [ERR_W-1:0] OVR_HI = ERR_W'(OVERRIDE_LIMIT);
	localparam logic signed [ERR_W-1:0] OVR_LO = -OVR_HI;

	logic                   valid_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;

	logic                            valid_s2;
	logic signed [ERR_W-1:0]         err_s2;
	logic signed [ERR_W:0]           diff_s2;
	logic signed [INTEGRAL_BITS-1:0] integ_s2;

	logic signed [ERR_W-1:0]         frame_q;
	logic signed [ERR_W-1:0]         prev_q;
	logic signed [INTEGRAL_BITS-1:0] integ_q;

	logic                            en1, en2, take;
	logic                            above, is_front, over;
	logic signed [ERR_W:0]           wsum;
	logic signed [ERR_W-1:0]         frame_next, err_cur;
	logic signed [ERR_W:0]           diff_cur;
	logic signed [INTEGRAL_BITS:0]   isum;
	logic signed [INTEGRAL_BITS-1:0] integ_next;

	assign en2          = !valid_s2 || stage_ready;
	assign en1          = !valid_s1 || en2;
	assign take         = valid_s1 && en2;
	assign sample.ready = en1;

	always_comb begin
		above    = CMP_W'(sample_s1) > CMP_W'(cfg.threshold);
		is_front = (idx_s1 == FRONT_INDEX);

		wsum = (ERR_W+1)'(frame_q) + (ERR_W+1)'(sensor_weight(idx_s1));
		if (wsum > ERR_HI)
			frame_next = ERR_W'(ERR_HI);
		else if (wsum < ERR_LO)
			frame_next = ERR_W'(ERR_LO);
		else
			frame_next = wsum[ERR_W-1:0];

		over    = (frame_q > OVR_HI) || (frame_q < OVR_LO);
		err_cur = (over && above) ? '0 : frame_q;

		diff_cur = (ERR_W+1)'(err_cur) - (ERR_W+1)'(prev_q);

		isum = (INTEGRAL_BITS+1)'(integ_q) + (INTEGRAL_BITS+1)'(err_cur);
		if (isum[INTEGRAL_BITS] != isum[INTEGRAL_BITS-1])
			integ_next = isum[INTEGRAL_BITS] ? {1'b1, {(INTEGRAL_BITS-1){1'b0}}}
				: {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
		else
			integ_next = isum[INTEGRAL_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && sample.valid) begin
			idx_s1    <= sample.sensor_index;
			sample_s1 <= sample.sensor_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			prev_q  <= '0;
			integ_q <= '0;
		end else if (take) begin
			if (is_front) begin
				frame_q <= '0;
				prev_q  <= err_cur;
				integ_q <= integ_next;
			end else if (above) begin
				frame_q <= frame_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1 && is_front;
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_front) begin
			err_s2   <= err_cur;
			diff_s2  <= diff_cur;
			integ_s2 <= integ_next;
		end
	end

	assign stage_o.valid = valid_s2;
	assign stage_o.err   = err_s2;
	assign stage_o.diff  = diff_s2;
	assign integ_o       = integ_s2;

endmodule

@@ rtl/core/lspid_pid_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspid_pid_stage
// Gain products, PID sum with 16-bit saturation and the result register.
// ----------------------------------------------------------------------------
module lspid_pid_stage #(
	parameter int INTEGRAL_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lspid_pkg::cfg_t                 cfg,
	input  lspid_pkg::err_stage_t           stage_i,
	input  logic signed [INTEGRAL_BITS-1:0] integ_i,
	output logic                            stage_ready,
	lspid_steer_if.source                   steer
);
	import lspid_pkg::*;

	localparam int PP_W  = GAIN_W + ERR_W;
	localparam int PD_W  = GAIN_W + ERR_W + 1;
	localparam int PI_W  = GAIN_W + INTEGRAL_BITS;
	localparam int SUM_W = PI_W + 2;

	logic                    valid_s3;
	logic signed [PP_W-1:0]  pp_s3;
	logic signed [PI_W-1:0]  pi_s3;
	logic signed [PD_W-1:0]  pd_s3;
	logic signed [ERR_W-1:0] err_s3;

	logic                      out_valid_q;
	logic signed [TURN_W-1:0]  turn_q;
	logic signed [SPEED_W-1:0] speed_q;
	logic signed [ERR_W-1:0]   err_q;

	logic                       en_o, en3;
	logic signed [SUM_W-1:0]    sum;
	logic [SUM_W-TURN_W:0]      hi_bits;
	logic signed [TURN_W-1:0]   turn_next;

	assign en_o        = !out_valid_q || steer.ready;
	assign en3         = !valid_s3 || en_o;
	assign stage_ready = en3;

	always_comb begin
		sum = SUM_W'(pp_s3) + SUM_W'(pi_s3) + SUM_W'(pd_s3);
		hi_bits = sum[SUM_W-1:TURN_W-1];
		if ((&hi_bits) || !(|hi_bits))
			turn_next = sum[TURN_W-1:0];
		else
			turn_next = sum[SUM_W-1] ? {1'b1, {(TURN_W-1){1'b0}}}
				: {1'b0, {(TURN_W-1){1'b1}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= stage_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && stage_i.valid) begin
			pp_s3  <= PP_W'($signed(cfg.gain_p)) * PP_W'(stage_i.err);
			pi_s3  <= PI_W'($signed(cfg.gain_i)) * PI_W'(integ_i);
			pd_s3  <= PD_W'($signed(cfg.gain_d)) * PD_W'(stage_i.diff);
			err_s3 <= stage_i.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_o) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o && valid_s3) begin
			turn_q  <= turn_next;
			speed_q <= cfg.base_speed;
			err_q   <= err_s3;
		end
	end

	assign steer.valid       = out_valid_q;
	assign steer.turn_rate   = turn_q;
	assign steer.drive_speed = speed_q;
	assign steer.line_error  = err_q;

endmodule

@@ rtl/core/line_sensor_pid_steering.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_sensor_pid_steering
// PID steering from a weighted reflectance sensor array, one sample per transfer.
// ----------------------------------------------------------------------------
// Takes one sample per cycle unless a stalled result backs up the pipe. Line
// sensors 0..14 above threshold add their position weight to the frame
// error; the front sensor (index 15) closes the frame and yields one
// steering result. A front sample passes the input register, error/integral
// stage, product stage and result register before it appears on the steer
// channel. The frame error update in the error stage, done for each sample,
// sets the one-sample-per-cycle rate. Each stage holds only while its successor
// is full and stalled, so samples keep flowing while a finished result waits.
module line_sensor_pid_steering #(
	parameter int SAMPLE_BITS   = 12,
	parameter int INTEGRAL_BITS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	lspid_sample_if.sink  sample,
	lspid_steer_if.source steer,
	lspid_cfg_if.sink     cfg
);
	import lspid_pkg::*;

	cfg_t                            cfg_regs;
	err_stage_t                      err_stage;
	logic signed [INTEGRAL_BITS-1:0] integ;
	logic                            pid_ready;

	lspid_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_o  (cfg_regs)
	);

	lspid_error_stage #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.INTEGRAL_BITS (INTEGRAL_BITS)
	) u_error_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (sample),
		.cfg         (cfg_regs),
		.stage_o     (err_stage),
		.integ_o     (integ),
		.stage_ready (pid_ready)
	);

	lspid_pid_stage #(
		.INTEGRAL_BITS (INTEGRAL_BITS)
	) u_pid_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_regs),
		.stage_i     (err_stage),
		.integ_i     (integ),
		.stage_ready (pid_ready),
		.steer       (steer)
	);

	// input backpressure only comes from a full pipe behind a stalled result
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (steer.valid && !steer.ready))
		else $error("sample stalled without a stalled result");

	a_line_error_range: assert property (@(posedge clk) disable iff (!arst_n)
		steer.valid |-> ((steer.line_error <= 6'sd21) && (steer.line_error >= -6'sd21)))
		else $error("line error outside frame range");

	a_diff_range: assert property (@(posedge clk) disable iff (!arst_n)
		err_stage.valid |-> ((err_stage.diff <= 7'sd42) && (err_stage.diff >= -7'sd42)))
		else $error("error difference outside range");

endmodule
